// ===== hw/rtl/arp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types, codes and sizes for the ARP responder and its address cache.
// ----------------------------------------------------------------------------
package arp_pkg;

    // Cache geometry
    localparam int CACHE_DEPTH = 128;
    localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CNT_W = $clog2(CACHE_DEPTH + 1);

    // Configuration register indexes
    localparam logic REG_OWN_IP  = 1'b0;
    localparam logic REG_OWN_MAC = 1'b1;

    // Transaction kinds
    localparam logic FUNC_MESSAGE = 1'b0;
    localparam logic FUNC_QUERY   = 1'b1;

    // Result kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_REPLY  = 3'd1;
    localparam logic [2:0] KIND_MISS   = 3'd2;
    localparam logic [2:0] KIND_HIT    = 3'd3;
    localparam logic [2:0] KIND_STORED = 3'd4;

    // Field values, in the byte order the parser delivers them
    localparam logic [15:0] OP_REQUEST  = 16'h0100;
    localparam logic [15:0] OP_REPLY    = 16'h0200;
    localparam logic [15:0] HW_TYPE_ETH = 16'h0100;
    localparam logic [15:0] PROTO_IPV4  = 16'h0008;
    localparam logic [7:0]  HW_LEN_ETH  = 8'd6;
    localparam logic [7:0]  PROTO_LEN_IPV4 = 8'd4;
    localparam logic [15:0] MIN_PAYLOAD = 16'd28;
    localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] IP_BCAST    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        func;
        logic [15:0] payload_size;
        logic [15:0] hw_type;
        logic [15:0] protocol_type;
        logic [7:0]  hw_addr_len;
        logic [7:0]  proto_addr_len;
        logic [15:0] opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [31:0] query_ip;
    } arp_in_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] tx_opcode;
        logic [47:0] tx_dest_mac;
        logic [31:0] tx_dest_ip;
        logic [47:0] found_mac;
    } arp_out_t;

    // One cache entry
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } arp_entry_t;

    // Commands from the responder to the cache
    typedef struct packed {
        logic        lookup;
        logic        store;
        logic [31:0] ip;
        logic [47:0] mac;
    } arp_cache_req_t;

    // Status from the cache
    typedef struct packed {
        logic        done;
        logic        hit;
        logic [47:0] mac;
        logic        full;
    } arp_cache_rsp_t;

endpackage : arp_pkg
`default_nettype wire

// ===== hw/rtl/arp_responder_and_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arp_responder_and_cache
// ARP responder for IPv4 over Ethernet with an append-only address cache.
// ----------------------------------------------------------------------------
// Every accepted transaction on the item channel yields exactly one result
// transaction. Items are handled one at a time: item_stall stays high from
// acceptance until the result has been moved into the output register, which
// may still hold the previous result while the next item is being worked on.
// A received message is decoded in ST_EVAL and its result is moved into the
// output register in ST_SEND, which raises result_valid. A query walks the
// cache RAM one entry per cycle through its single registered read port,
// and reads only the stored entries (at most CACHE_DEPTH = 128); it stops
// early at the first matching entry. A broadcast query does not use the
// cache. The next item can be taken in the cycle after the output load.
// Valid responses aimed at own_ip are appended in arrival order, duplicates
// included, and dropped once the cache is full. The cache RAM is not cleared
// at reset; its entry count is, so no clearing pass is needed. Configuration
// (cfg_index 0 = own_ip, 1 = own_mac) must be written only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module arp_responder_and_cache
    import arp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [47:0] cfg_data,
    // item channel
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire arp_in_t     item,
    // result channel
    output logic             result_valid,
    input  wire logic        result_stall,
    output arp_out_t         result
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_SEND = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [31:0]    own_ip_reg, own_ip_next;
    // own MAC register; no result field carries it
    logic [47:0]    own_mac_reg, own_mac_next;
    arp_in_t        item_reg, item_next;
    arp_out_t       res_reg, res_next;
    arp_out_t       result_reg, result_next;
    logic           result_valid_reg, result_valid_next;

    arp_cache_req_t cache_req;
    arp_cache_rsp_t cache_rsp;

    logic           msg_ok;
    logic           out_free;

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // output register can take a new result this cycle
    assign out_free = !result_valid_reg || !result_stall;

    // header checks on a received message, including target == own IP
    assign msg_ok = (item_reg.payload_size >= MIN_PAYLOAD)
                 && (item_reg.hw_type == HW_TYPE_ETH)
                 && (item_reg.protocol_type == PROTO_IPV4)
                 && (item_reg.hw_addr_len == HW_LEN_ETH)
                 && (item_reg.proto_addr_len == PROTO_LEN_IPV4)
                 && (item_reg.target_ip == own_ip_reg);

    arp_cache u_cache (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cache_req),
        .rsp   (cache_rsp)
    );

    always_comb
    begin
        state_next        = state_reg;
        own_ip_next       = own_ip_reg;
        own_mac_next      = own_mac_reg;
        item_next         = item_reg;
        res_next          = res_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        cache_req.lookup  = 1'b0;
        cache_req.store   = 1'b0;
        cache_req.ip      = (item_reg.func == FUNC_QUERY) ? item_reg.query_ip
                                                          : item_reg.sender_ip;
        cache_req.mac     = item_reg.sender_mac;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OWN_IP:  own_ip_next  = cfg_data[31:0];
                REG_OWN_MAC: own_mac_next = cfg_data;
                default:     ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                // defaults for fields with no meaning
                res_next = '{result_kind: KIND_NONE, tx_opcode: '0,
                             tx_dest_mac: '0, tx_dest_ip: '0,
                             found_mac: MAC_BCAST};
                state_next = ST_SEND;
                if (item_reg.func == FUNC_QUERY)
                begin
                    if (item_reg.query_ip == IP_BCAST)
                    begin
                        res_next.result_kind = KIND_HIT;
                    end
                    else
                    begin
                        cache_req.lookup = 1'b1;
                        state_next       = ST_SCAN;
                    end
                end
                else if (msg_ok)
                begin
                    priority if (item_reg.opcode == OP_REQUEST)
                    begin
                        res_next.result_kind = KIND_REPLY;
                        res_next.tx_opcode   = OP_REPLY;
                        res_next.tx_dest_mac = item_reg.sender_mac;
                        res_next.tx_dest_ip  = item_reg.sender_ip;
                    end
                    else if (item_reg.opcode == OP_REPLY && !cache_rsp.full)
                    begin
                        cache_req.store      = 1'b1;
                        res_next.result_kind = KIND_STORED;
                    end
                    else
                    begin
                        res_next.result_kind = KIND_NONE;
                    end
                end
            end

            ST_SCAN:
            begin
                if (cache_rsp.done)
                begin
                    if (cache_rsp.hit)
                    begin
                        res_next.result_kind = KIND_HIT;
                        res_next.found_mac   = cache_rsp.mac;
                    end
                    else
                    begin
                        // miss: broadcast a request for the address
                        res_next.result_kind = KIND_MISS;
                        res_next.tx_opcode   = OP_REQUEST;
                        res_next.tx_dest_mac = MAC_BCAST;
                        res_next.tx_dest_ip  = item_reg.query_ip;
                    end
                    state_next = ST_SEND;
                end
            end

            ST_SEND:
            begin
                if (out_free)
                begin
                    result_next       = res_reg;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            own_ip_reg       <= '0;
            own_mac_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            own_ip_reg       <= own_ip_next;
            own_mac_reg      <= own_mac_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        result_reg <= result_next;
    end

endmodule : arp_responder_and_cache
`default_nettype wire

// ===== hw/rtl/arp_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arp_cache
// IP/MAC pair store in one synchronous RAM; appends entries and scans them
// one per cycle for the first match.
// ----------------------------------------------------------------------------
module arp_cache
    import arp_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire arp_cache_req_t req,
    output arp_cache_rsp_t      rsp
);

    arp_entry_t mem [CACHE_DEPTH];
    arp_entry_t rd_data_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             busy_reg, busy_next;
    logic             pend_reg, pend_next;
    logic [31:0]      ip_reg, ip_next;

    logic             full;
    logic             store_en;
    logic             issue;
    logic             match;
    logic             done;

    assign full     = (count_reg == CNT_W'(CACHE_DEPTH));
    assign store_en = req.store && !full;
    // next read goes out while entries remain
    assign issue    = busy_reg && (scan_idx_reg < count_reg);
    assign match    = pend_reg && (rd_data_reg.ip == ip_reg);
    assign done     = busy_reg && (match || (!pend_reg && !issue));

    assign rsp.done = done;
    // a cached broadcast MAC counts as a miss
    assign rsp.hit  = match && (rd_data_reg.mac != MAC_BCAST);
    assign rsp.mac  = rd_data_reg.mac;
    assign rsp.full = full;

    always_comb
    begin
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        busy_next     = busy_reg;
        pend_next     = pend_reg;
        ip_next       = ip_reg;
        if (store_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (req.lookup)
        begin
            busy_next     = 1'b1;
            scan_idx_next = '0;
            pend_next     = 1'b0;
            ip_next       = req.ip;
        end
        else if (done)
        begin
            busy_next = 1'b0;
            pend_next = 1'b0;
        end
        else
        begin
            pend_next = issue;
            if (issue)
            begin
                scan_idx_next = scan_idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            scan_idx_reg <= '0;
            busy_reg     <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            busy_reg     <= busy_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg <= ip_next;
    end

    // RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= '{ip: req.ip, mac: req.mac};
        end
        if (issue)
        begin
            rd_data_reg <= mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

endmodule : arp_cache
`default_nettype wire
